@@ hw/rtl/tsl_pkg.sv @@
// Package for the transpose search list: sizes, mode and status codes,
// result and memory request structs, index helper.
// No dependencies.
package tsl_pkg;

  localparam int DEPTH   = 256;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int MODE_W  = 2;
  localparam int DATA_W  = 32;
  localparam int POS_W   = 9;
  localparam int STAT_W  = 2;
  localparam int FIDX_W  = 8;
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int IDXX_W  = (ADDR_W > FIDX_W) ? ADDR_W : FIDX_W;

  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_XPOSE  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

  localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [FIDX_W-1:0]        found_index;
    logic signed [DATA_W-1:0] entry_value;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [FIDX_W-1:0] found_idx(input logic [ADDR_W-1:0] a);
    logic [IDXX_W-1:0] t;
    t = IDXX_W'(a);
    return t[FIDX_W-1:0];
  endfunction

endpackage

@@ hw/rtl/tsl_in_if.sv @@
// Input channel of the transpose search list: valid/ready plus item fields.
// Depends on tsl_pkg.
interface tsl_in_if;
  import tsl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [DATA_W-1:0] item_value;
  logic [POS_W-1:0]         position;

  modport source (output valid, output mode, output item_value, output position,
                  input ready);
  modport sink   (input valid, input mode, input item_value, input position,
                  output ready);
endinterface

@@ hw/rtl/tsl_out_if.sv @@
// Result channel of the transpose search list: valid/ready plus result fields.
// Depends on tsl_pkg.
interface tsl_out_if;
  import tsl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic [FIDX_W-1:0]        found_index;
  logic signed [DATA_W-1:0] entry_value;

  modport source (output valid, output status, output found_index,
                  output entry_value, input ready);
  modport sink   (input valid, input status, input found_index,
                  input entry_value, output ready);
endinterface

@@ hw/rtl/transpose_search_list.sv @@
// Transpose search list top: sequencer, entry RAM, output register.
// Path from input beat to output valid: append, full or empty-list miss go straight to
// result staging; a read passes through the RAM read state; a search scans entries from
// index 0 up to the hit or the tail, plus a swap state for a transpose hit.
// One item at a time, next beat the cycle after the result leaves the sequencer.
// Sync reset, no clear pass.
module transpose_search_list (
  input  logic      clk,
  input  logic      rst_n,
  tsl_in_if.sink    in_item,
  tsl_out_if.source out_result
);
  import tsl_pkg::*;

  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r;

  tsl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  tsl_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_valid_r || out_result.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_result.valid       = out_valid_r;
  assign out_result.status      = out_res_r.status;
  assign out_result.found_index = out_res_r.found_index;
  assign out_result.entry_value = out_res_r.entry_value;

endmodule

@@ hw/rtl/tsl_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tsl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/tsl_ctrl.sv @@
// Sequencer of the transpose search list: entry count, linear scan over the
// entry RAM, transpose write-back, result staging. Depends on tsl_pkg, tsl_in_if.
module tsl_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  tsl_in_if.sink                in_item,
  output tsl_pkg::mem_req_t     mem_req,
  input  logic [tsl_pkg::DATA_W-1:0] mem_rdata,
  output logic                  res_valid,
  output tsl_pkg::res_t         res,
  input  logic                  res_ready
);
  import tsl_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_SWAP   = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  localparam res_t RES_MISS = '{status: STATUS_MISS, found_index: '0, entry_value: '0};

  logic [2:0]        state_r,  state_nxt;
  logic [CNT_W-1:0]  count_r,  count_nxt;
  logic [ADDR_W-1:0] idx_r,    idx_nxt;
  logic [MODE_W-1:0] mode_r,   mode_nxt;
  logic [DATA_W-1:0] value_r,  value_nxt;
  logic [DATA_W-1:0] prev_r,   prev_nxt;
  res_t              res_r,    res_nxt;
  logic [ADDR_W-1:0] rd_pos;
  logic              scan_last;

  assign rd_pos    = ADDR_W'(in_item.position - POS_W'(1));
  assign scan_last = (CNT_W'(idx_r) + CNT_W'(1)) == count_r;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    mode_nxt  = mode_r;
    value_nxt = value_r;
    prev_nxt  = prev_r;
    res_nxt   = res_r;
    mem_req   = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_item.valid) begin
          mode_nxt  = in_item.mode;
          value_nxt = in_item.item_value;
          state_nxt = ST_RESULT;
          case (in_item.mode)
            MODE_APPEND: begin
              if (count_r >= CNT_W'(DEPTH)) begin
                res_nxt = '{status: STATUS_FULL, found_index: '0,
                            entry_value: in_item.item_value};
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ADDR_W'(count_r);
                mem_req.wdata = in_item.item_value;
                count_nxt     = count_r + CNT_W'(1);
                res_nxt = '{status: STATUS_OK, found_index: found_idx(ADDR_W'(count_r)),
                            entry_value: in_item.item_value};
              end
            end
            MODE_SEARCH, MODE_XPOSE: begin
              if (count_r == '0) begin
                res_nxt = RES_MISS;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = '0;
                idx_nxt       = '0;
                state_nxt     = ST_SCAN;
              end
            end
            MODE_READ: begin
              if (in_item.position == '0 ||
                  CMP_W'(in_item.position) > CMP_W'(count_r)) begin
                res_nxt = RES_MISS;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = rd_pos;
                idx_nxt       = rd_pos;
                state_nxt     = ST_READ;
              end
            end
            default: begin
              res_nxt = RES_MISS;
            end
          endcase
        end
      end
      ST_READ: begin
        res_nxt   = '{status: STATUS_OK, found_index: found_idx(idx_r),
                      entry_value: mem_rdata};
        state_nxt = ST_RESULT;
      end
      ST_SCAN: begin
        if (mem_rdata == value_r) begin
          if (mode_r == MODE_XPOSE && idx_r != '0) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = idx_r - ADDR_W'(1);
            mem_req.wdata = value_r;
            state_nxt     = ST_SWAP;
          end else begin
            res_nxt   = '{status: STATUS_OK, found_index: found_idx(idx_r),
                          entry_value: value_r};
            state_nxt = ST_RESULT;
          end
        end else if (scan_last) begin
          res_nxt   = RES_MISS;
          state_nxt = ST_RESULT;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_r + ADDR_W'(1);
          idx_nxt       = idx_r + ADDR_W'(1);
          prev_nxt      = mem_rdata;
        end
      end
      ST_SWAP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r;
        mem_req.wdata = prev_r;
        res_nxt   = '{status: STATUS_OK, found_index: found_idx(idx_r - ADDR_W'(1)),
                      entry_value: value_r};
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    idx_r   <= idx_nxt;
    mode_r  <= mode_nxt;
    value_r <= value_nxt;
    prev_r  <= prev_nxt;
    res_r   <= res_nxt;
  end

  assign in_item.ready = (state_r == ST_IDLE);
  assign res_valid     = (state_r == ST_RESULT);
  assign res           = res_r;

  a_no_rw_same_addr: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.we && mem_req.re && mem_req.waddr == mem_req.raddr))
    else $error("tsl_ctrl: read and write of one entry in the same cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("tsl_ctrl: entry count beyond depth");

  a_scan_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_SWAP) |-> CNT_W'(idx_r) < count_r)
    else $error("tsl_ctrl: scan index outside stored entries");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_item.valid && in_item.ready && in_item.mode == MODE_APPEND &&
     count_r < CNT_W'(DEPTH)) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("tsl_ctrl: append beat did not grow the list");

endmodule

@@ verif/testbench.sv @@
// Testbench for transpose_search_list: directed and random list traffic, checked
// beat by beat against an in-bench list predictor, with sender and receiver idling.
// Depends on tsl_pkg, tsl_in_if, tsl_out_if and the transpose_search_list RTL.
`timescale 1ns / 1ps

module testbench;
  import tsl_pkg::*;

  logic clk;
  logic rst_n;

  tsl_in_if  in_ch ();
  tsl_out_if out_ch ();

  transpose_search_list i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_ch.sink),
    .out_result (out_ch.source)
  );

  logic signed [DATA_W-1:0] list_entries [DEPTH];
  int                       list_count;
  res_t                     expected_results [$];
  int                       mismatch_count;
  int                       send_idle_pct;
  int                       recv_stall_pct;
  int                       hold_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic res_t predict_list_op(input logic [MODE_W-1:0] mode,
                                           input logic signed [DATA_W-1:0] value,
                                           input logic [POS_W-1:0] pos);
    res_t                     r;
    int                       hit;
    int                       i;
    logic signed [DATA_W-1:0] tmp;
    r.status      = STATUS_MISS;
    r.found_index = '0;
    r.entry_value = '0;
    hit = -1;
    for (i = 0; i < list_count; i++) begin
      if (hit < 0 && list_entries[i] == value) hit = i;
    end
    case (mode)
      MODE_APPEND: begin
        if (list_count >= DEPTH) begin
          r.status      = STATUS_FULL;
          r.entry_value = value;
        end else begin
          list_entries[list_count] = value;
          r.status      = STATUS_OK;
          r.found_index = FIDX_W'(list_count);
          r.entry_value = value;
          list_count++;
        end
      end
      MODE_SEARCH, MODE_XPOSE: begin
        if (hit >= 0) begin
          if (mode == MODE_XPOSE && hit > 0) begin
            tmp                   = list_entries[hit-1];
            list_entries[hit-1]   = list_entries[hit];
            list_entries[hit]     = tmp;
            hit--;
          end
          r.status      = STATUS_OK;
          r.found_index = FIDX_W'(hit);
          r.entry_value = value;
        end
      end
      default: begin
        if (pos != 0 && pos <= list_count) begin
          r.status      = STATUS_OK;
          r.found_index = FIDX_W'(pos - 1);
          r.entry_value = list_entries[pos-1];
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_item(input logic [MODE_W-1:0] mode,
                           input logic signed [DATA_W-1:0] value,
                           input logic [POS_W-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= mode;
    in_ch.item_value <= value;
    in_ch.position   <= pos;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(predict_list_op(mode, value, pos));
  endtask

  // result checker and ready generator
  initial begin
    res_t exp_res;
    int   hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected beat: status %0d index %0d value %0d",
                     out_ch.status, out_ch.found_index, out_ch.entry_value);
        end else begin
          exp_res = expected_results.pop_front();
          if (out_ch.status !== exp_res.status ||
              out_ch.found_index !== exp_res.found_index ||
              out_ch.entry_value !== exp_res.entry_value) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: exp status %0d index %0d value %0d, got %0d %0d %0d",
                       exp_res.status, exp_res.found_index, exp_res.entry_value,
                       out_ch.status, out_ch.found_index, out_ch.entry_value);
          end
        end
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0, 1: return DATA_W'($urandom_range(15));
      2, 3: return $urandom;
      4: begin
        case ($urandom_range(3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return '0;
          default: return -1;
        endcase
      end
      default: begin
        if (list_count == 0) return $urandom;
        return list_entries[$urandom_range(list_count - 1)];
      end
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    case ($urandom_range(7))
      0: return '0;
      1: return POS_W'(list_count);
      2: return POS_W'(list_count + 1);
      3: return POS_W'($urandom_range(511));
      default: return (list_count == 0) ? POS_W'(1) : POS_W'($urandom_range(list_count, 1));
    endcase
  endfunction

  task automatic send_random_item();
    int r;
    r = $urandom_range(99);
    if (r < 25)      send_item(MODE_APPEND, pick_value(), POS_W'($urandom_range(511)));
    else if (r < 50) send_item(MODE_SEARCH, pick_value(), POS_W'($urandom_range(511)));
    else if (r < 75) send_item(MODE_XPOSE, pick_value(), POS_W'($urandom_range(511)));
    else             send_item(MODE_READ, $urandom, pick_position());
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_list();
    send_item(MODE_SEARCH, '0, '0);
    send_item(MODE_XPOSE, 32'sd5, 9'd3);
    send_item(MODE_READ, '0, 9'd1);
    send_item(MODE_READ, '0, 9'd0);
  endtask

  task automatic test_directed_ops();
    send_item(MODE_APPEND, 32'sh7FFF_FFFF, 9'd511);
    send_item(MODE_APPEND, 32'sh8000_0000, 9'd0);
    send_item(MODE_APPEND, '0, 9'd256);
    send_item(MODE_APPEND, -32'sd1, 9'd1);
    send_item(MODE_APPEND, 32'sd1, 9'd2);
    send_item(MODE_APPEND, 32'sd7, 9'd3);
    send_item(MODE_APPEND, 32'sd7, 9'd4);
    send_item(MODE_SEARCH, 32'sd7, 9'd0);
    send_item(MODE_XPOSE, 32'sh7FFF_FFFF, 9'd0);
    send_item(MODE_XPOSE, 32'sh8000_0000, 9'd0);
    send_item(MODE_SEARCH, 32'sh7FFF_FFFF, 9'd0);
    send_item(MODE_XPOSE, -32'sd1, 9'd0);
    send_item(MODE_SEARCH, 32'sd12345, 9'd0);
    send_item(MODE_XPOSE, 32'sd99, 9'd0);
    send_item(MODE_READ, '0, 9'd0);
    send_item(MODE_READ, -32'sd1, 9'd1);
    send_item(MODE_READ, '0, 9'd7);
    send_item(MODE_READ, '0, 9'd8);
    send_item(MODE_READ, '0, 9'd511);
    send_item(MODE_READ, '0, 9'd256);
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 400;
    repeat (8) send_random_item();
  endtask

  task automatic test_random_traffic(input int n, input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (n) send_random_item();
  endtask

  initial begin
    list_count       = 0;
    mismatch_count   = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_req         = 0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.mode       <= MODE_APPEND;
    in_ch.item_value <= '0;
    in_ch.position   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_directed_ops();
    test_backpressure();
    test_random_traffic(390, 0, 0);
    test_random_traffic(390, 66, 0);
    test_random_traffic(390, 0, 66);
    test_random_traffic(390, 19, 19);
    in_ch.valid <= 1'b0;

    wait_drained();
    repeat (DEPTH + 8) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/tsl_pkg.sv
hw/rtl/tsl_in_if.sv
hw/rtl/tsl_out_if.sv
hw/rtl/tsl_ram.sv
hw/rtl/tsl_ctrl.sv
hw/rtl/transpose_search_list.sv
verif/testbench.sv
